// ===== design/scrs_pkg.sv =====
// ----------------------------------------------------------------------------
// scrs_pkg
// Shared types, codes and sizes for the SMTP client reply sequencer.
// ----------------------------------------------------------------------------
package scrs_pkg;

  // Sizes
  localparam int QUEUE_DEPTH    = 16;
  localparam int MAX_RECIPIENTS = 8;
  localparam int Q_AW           = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int Q_FILL_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W           = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ENC_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_AUTH      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RCPT_CNT  = 2'd2;

  // Encryption modes
  localparam logic [1:0] MODE_NONE     = 2'd0;
  localparam logic [1:0] MODE_SSL      = 2'd1;
  localparam logic [1:0] MODE_STARTTLS = 2'd2;

  localparam logic AUTH_LOGIN = 1'b0;

  // Event kinds
  localparam logic [2:0] KIND_REPLY      = 3'd0;
  localparam logic [2:0] KIND_UNPARSABLE = 3'd1;
  localparam logic [2:0] KIND_ENCRYPTED  = 3'd2;
  localparam logic [2:0] KIND_CLOSED     = 3'd3;
  localparam logic [2:0] KIND_SOCK_ERR   = 3'd4;
  localparam logic [2:0] KIND_MAIL_REQ   = 3'd5;
  localparam logic [2:0] KIND_TEST_LOGIN = 3'd6;

  // Reply codes
  localparam logic [9:0] RC_READY      = 10'd220;
  localparam logic [9:0] RC_OK         = 10'd250;
  localparam logic [9:0] RC_CHALLENGE  = 10'd334;
  localparam logic [9:0] RC_AUTH_OK    = 10'd235;
  localparam logic [9:0] RC_START_DATA = 10'd354;

  // Commands
  localparam logic [3:0] CMD_NONE      = 4'd0;
  localparam logic [3:0] CMD_EHLO      = 4'd1;
  localparam logic [3:0] CMD_STARTTLS  = 4'd2;
  localparam logic [3:0] CMD_AUTH_LOGIN = 4'd3;
  localparam logic [3:0] CMD_AUTH_PLAIN = 4'd4;
  localparam logic [3:0] CMD_USER      = 4'd5;
  localparam logic [3:0] CMD_PASS      = 4'd6;
  localparam logic [3:0] CMD_MAIL_FROM = 4'd7;
  localparam logic [3:0] CMD_RCPT      = 4'd8;
  localparam logic [3:0] CMD_DATA      = 4'd9;
  localparam logic [3:0] CMD_BODY      = 4'd10;
  localparam logic [3:0] CMD_QUIT      = 4'd11;

  // Link actions
  localparam logic [2:0] LINK_NONE         = 3'd0;
  localparam logic [2:0] LINK_CLOSE        = 3'd1;
  localparam logic [2:0] LINK_CONNECT      = 3'd2;
  localparam logic [2:0] LINK_CONNECT_SSL  = 3'd3;
  localparam logic [2:0] LINK_START_TLS    = 3'd4;

  // Reports
  localparam logic [2:0] REP_NONE       = 3'd0;
  localparam logic [2:0] REP_MAIL_SENT  = 3'd1;
  localparam logic [2:0] REP_MAIL_FAIL  = 3'd2;
  localparam logic [2:0] REP_LOGIN_OK   = 3'd3;
  localparam logic [2:0] REP_LOGIN_FAIL = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE      = 4'd0,
    ST_INIT      = 4'd1,
    ST_HANDSHAKE = 4'd2,
    ST_STARTTLS  = 4'd3,
    ST_AUTH      = 4'd4,
    ST_USER      = 4'd5,
    ST_PASS      = 4'd6,
    ST_TESTDONE  = 4'd7,
    ST_MAIL      = 4'd8,
    ST_RCPT      = 4'd9,
    ST_DATA      = 4'd10,
    ST_BODY      = 4'd11,
    ST_QUIT      = 4'd12,
    ST_CLOSE     = 4'd13
  } seq_state_t;

  typedef struct packed {
    logic [3:0]      command;
    logic [2:0]      recipient_slot;
    logic [2:0]      link_action;
    logic [2:0]      report;
    logic [ID_W-1:0] report_mail_id;
    logic [ID_W-1:0] assigned_mail_id;
    logic            request_dropped;
    logic [3:0]      protocol_state;
  } result_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctl_t;

  typedef struct packed {
    logic            empty;
    logic            full;
    logic [ID_W-1:0] head_id;
  } q_stat_t;

endpackage

// ===== design/scrs_if.sv =====
// ----------------------------------------------------------------------------
// scrs interfaces
// Valid/ready channels for events, results and configuration writes.
// ----------------------------------------------------------------------------
interface scrs_in_if import scrs_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [9:0] reply_code;
  logic       final_line;

  modport source (output valid, kind, reply_code, final_line, input ready);
  modport sink   (input valid, kind, reply_code, final_line, output ready);
endinterface

interface scrs_out_if import scrs_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [3:0]      command;
  logic [2:0]      recipient_slot;
  logic [2:0]      link_action;
  logic [2:0]      report;
  logic [ID_W-1:0] report_mail_id;
  logic [ID_W-1:0] assigned_mail_id;
  logic            request_dropped;
  logic [3:0]      protocol_state;

  modport source (output valid, command, recipient_slot, link_action, report,
                  report_mail_id, assigned_mail_id, request_dropped, protocol_state,
                  input ready);
  modport sink   (input valid, command, recipient_slot, link_action, report,
                  report_mail_id, assigned_mail_id, request_dropped, protocol_state,
                  output ready);
endinterface

interface scrs_cfg_if import scrs_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/scrs_queue.sv =====
// ----------------------------------------------------------------------------
// scrs_queue
// FIFO of pending mail ids with head bypass for a push into an empty queue.
// ----------------------------------------------------------------------------
module scrs_queue import scrs_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  q_ctl_t          ctl,
  input  logic [ID_W-1:0] push_id,
  output q_stat_t         stat
);

  logic [ID_W-1:0]     mem_r [QUEUE_DEPTH];
  logic [Q_AW-1:0]     head_r, head_nxt;
  logic [Q_AW-1:0]     tail_r, tail_nxt;
  logic [Q_FILL_W-1:0] fill_r, fill_nxt;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (ctl.push) begin
      tail_nxt = (tail_r == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
    end
    if (ctl.pop) begin
      head_nxt = (head_r == Q_AW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (ctl.push && !ctl.pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (ctl.pop && !ctl.push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem_r[tail_r] <= push_id;
    end
  end

  // A pop from an empty queue can only follow a push in the same event.
  assign stat.empty   = (fill_r == '0);
  assign stat.full    = (fill_r == Q_FILL_W'(QUEUE_DEPTH));
  assign stat.head_id = stat.empty ? push_id : mem_r[head_r];

endmodule

// ===== design/scrs_fsm.sv =====
// ----------------------------------------------------------------------------
// scrs_fsm
// Protocol state, flags and mail-id bookkeeping; forms one result per event.
// ----------------------------------------------------------------------------
module scrs_fsm import scrs_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            fire,
  input  logic [2:0]      kind,
  input  logic [9:0]      reply_code,
  input  logic            final_line,
  input  logic [1:0]      enc_mode,
  input  logic            auth_method,
  input  logic [3:0]      rcpt_count,
  input  q_stat_t         q_stat,
  output q_ctl_t          q_ctl,
  output logic [ID_W-1:0] push_id,
  output result_t         result
);

  seq_state_t      state_r, state_nxt;
  logic            enc_r, enc_nxt;
  logic            test_r, test_nxt;
  logic [3:0]      cursor_r, cursor_nxt;
  logic [ID_W-1:0] active_r, active_nxt;
  logic [ID_W-1:0] next_id_r, next_id_nxt;

  logic [1:0] mode_eff;
  logic [3:0] count_eff;
  logic [3:0] cursor_inc;
  logic       info250;
  logic       is_fail;
  logic       try_next;
  logic       push;
  logic       pop;
  logic [2:0] connect_act;

  assign mode_eff    = (enc_mode == 2'd3) ? MODE_NONE : enc_mode;
  assign count_eff   = (rcpt_count == 4'd0) ? 4'd1 :
                       (rcpt_count > 4'(MAX_RECIPIENTS)) ? 4'(MAX_RECIPIENTS) : rcpt_count;
  assign cursor_inc  = cursor_r + 4'd1;
  assign info250     = (reply_code == RC_OK) && !final_line;
  assign connect_act = (mode_eff == MODE_SSL) ? LINK_CONNECT_SSL : LINK_CONNECT;

  // Next state and bookkeeping.
  always_comb begin
    state_nxt   = state_r;
    enc_nxt     = enc_r;
    test_nxt    = test_r;
    cursor_nxt  = cursor_r;
    active_nxt  = active_r;
    next_id_nxt = next_id_r;
    is_fail     = 1'b0;
    try_next    = 1'b0;
    push        = 1'b0;
    pop         = 1'b0;

    unique case (kind) inside
      KIND_REPLY: begin
        unique case (state_r)
          ST_IDLE: try_next = 1'b1;
          ST_INIT: begin
            if (reply_code == RC_READY) begin
              state_nxt = (mode_eff == MODE_NONE) ? ST_AUTH :
                          (mode_eff == MODE_SSL)  ? ST_HANDSHAKE : ST_STARTTLS;
            end
          end
          ST_HANDSHAKE: begin
            if (reply_code != RC_OK && reply_code != RC_READY) is_fail = 1'b1;
          end
          ST_STARTTLS: begin
            if (!info250) begin
              if (reply_code == RC_OK) state_nxt = ST_HANDSHAKE;
              else is_fail = 1'b1;
            end
          end
          ST_AUTH: begin
            if (!info250) begin
              if (reply_code == RC_OK || reply_code == RC_READY) begin
                if (auth_method == AUTH_LOGIN) state_nxt = ST_USER;
                else state_nxt = test_r ? ST_TESTDONE : ST_MAIL;
              end else begin
                is_fail = 1'b1;
              end
            end
          end
          ST_USER: begin
            if (reply_code == RC_CHALLENGE) state_nxt = ST_PASS;
            else is_fail = 1'b1;
          end
          ST_PASS: begin
            if (reply_code == RC_CHALLENGE) state_nxt = test_r ? ST_TESTDONE : ST_MAIL;
            else is_fail = 1'b1;
          end
          ST_TESTDONE: begin
            if (reply_code != RC_OK) begin
              enc_nxt  = 1'b0;
              test_nxt = 1'b0;
            end
          end
          ST_MAIL: begin
            if (reply_code != RC_OK) begin
              if (reply_code == RC_AUTH_OK) begin
                cursor_nxt = '0;
                state_nxt  = ST_RCPT;
              end else begin
                is_fail = 1'b1;
              end
            end
          end
          ST_RCPT: begin
            if (!info250) begin
              if (reply_code == RC_OK) begin
                cursor_nxt = cursor_inc;
                if (cursor_inc >= count_eff) state_nxt = ST_DATA;
              end else begin
                is_fail = 1'b1;
              end
            end
          end
          ST_DATA: begin
            if (!info250) begin
              if (reply_code == RC_OK) state_nxt = ST_BODY;
              else is_fail = 1'b1;
            end
          end
          ST_BODY: begin
            if (reply_code == RC_START_DATA) state_nxt = ST_QUIT;
            else is_fail = 1'b1;
          end
          ST_QUIT: begin
            if (!info250) begin
              if (reply_code == RC_OK) state_nxt = ST_CLOSE;
              else is_fail = 1'b1;
            end
          end
          ST_CLOSE: enc_nxt = 1'b0;
          default: ;
        endcase
      end
      KIND_UNPARSABLE, KIND_SOCK_ERR: begin
        if (state_r != ST_IDLE) is_fail = 1'b1;
      end
      KIND_ENCRYPTED: begin
        enc_nxt   = 1'b1;
        state_nxt = ST_AUTH;
      end
      KIND_CLOSED: begin
        enc_nxt   = 1'b0;
        state_nxt = ST_IDLE;
        try_next  = 1'b1;
      end
      KIND_MAIL_REQ: begin
        if (!q_stat.full) begin
          push        = 1'b1;
          next_id_nxt = next_id_r + 1'b1;
        end
        try_next = 1'b1;
      end
      KIND_TEST_LOGIN: begin
        test_nxt  = 1'b1;
        state_nxt = ST_INIT;
        enc_nxt   = 1'b0;
      end
      default: ;
    endcase

    if (is_fail) begin
      enc_nxt   = 1'b0;
      test_nxt  = 1'b0;
      state_nxt = ST_IDLE;
    end

    // Start the oldest queued mail when the dialogue is free.
    if (try_next && state_nxt == ST_IDLE && (!q_stat.empty || push)) begin
      pop        = 1'b1;
      active_nxt = q_stat.head_id;
      state_nxt  = ST_INIT;
      enc_nxt    = 1'b0;
    end
  end

  // Result fields.
  always_comb begin
    result = '0;
    result.protocol_state = state_nxt;

    unique case (kind)
      KIND_REPLY: begin
        unique case (state_r)
          ST_INIT: if (reply_code == RC_READY) result.command = CMD_EHLO;
          ST_HANDSHAKE: begin
            if (reply_code == RC_READY && !enc_r && mode_eff != MODE_NONE) begin
              result.link_action = LINK_START_TLS;
            end
          end
          ST_STARTTLS: if (!info250 && reply_code == RC_OK) result.command = CMD_STARTTLS;
          ST_AUTH: begin
            if (!info250 && (reply_code == RC_OK || reply_code == RC_READY)) begin
              result.command = (auth_method == AUTH_LOGIN) ? CMD_AUTH_LOGIN : CMD_AUTH_PLAIN;
            end
          end
          ST_USER: if (reply_code == RC_CHALLENGE) result.command = CMD_USER;
          ST_PASS: if (reply_code == RC_CHALLENGE) result.command = CMD_PASS;
          ST_TESTDONE: begin
            if (reply_code != RC_OK) begin
              result.report      = (reply_code == RC_AUTH_OK) ? REP_LOGIN_OK : REP_LOGIN_FAIL;
              result.link_action = LINK_CLOSE;
            end
          end
          ST_MAIL: if (reply_code == RC_AUTH_OK) result.command = CMD_MAIL_FROM;
          ST_RCPT: begin
            if (!info250 && reply_code == RC_OK) begin
              result.command        = CMD_RCPT;
              result.recipient_slot = cursor_r[2:0];
            end
          end
          ST_DATA: if (!info250 && reply_code == RC_OK) result.command = CMD_DATA;
          ST_BODY: if (reply_code == RC_START_DATA) result.command = CMD_BODY;
          ST_QUIT: begin
            if (!info250 && reply_code == RC_OK) begin
              result.command        = CMD_QUIT;
              result.report         = REP_MAIL_SENT;
              result.report_mail_id = active_r;
            end
          end
          ST_CLOSE: result.link_action = LINK_CLOSE;
          default: ;
        endcase
      end
      KIND_ENCRYPTED: result.command = CMD_EHLO;
      KIND_MAIL_REQ: begin
        if (q_stat.full) result.request_dropped = 1'b1;
        else result.assigned_mail_id = next_id_r;
      end
      KIND_TEST_LOGIN: result.link_action = connect_act;
      default: ;
    endcase

    if (is_fail) begin
      result.command        = CMD_NONE;
      result.link_action    = LINK_CLOSE;
      result.report         = test_r ? REP_LOGIN_FAIL : REP_MAIL_FAIL;
      result.report_mail_id = test_r ? '0 : active_r;
    end
    if (pop) begin
      result.link_action = connect_act;
    end
  end

  assign q_ctl.push = fire && push;
  assign q_ctl.pop  = fire && pop;
  assign push_id    = next_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      enc_r     <= 1'b0;
      test_r    <= 1'b0;
      cursor_r  <= '0;
      active_r  <= '0;
      next_id_r <= '0;
    end else if (fire) begin
      state_r   <= state_nxt;
      enc_r     <= enc_nxt;
      test_r    <= test_nxt;
      cursor_r  <= cursor_nxt;
      active_r  <= active_nxt;
      next_id_r <= next_id_nxt;
    end
  end

endmodule

// ===== design/smtp_client_reply_sequencer.sv =====
// ----------------------------------------------------------------------------
// smtp_client_reply_sequencer
// SMTP client dialogue sequencer: one event word in, one result word out.
// ----------------------------------------------------------------------------
// Each event word is captured in an input register and, in the cycle it
// leaves that register, is run through the sequencer logic, which updates
// the protocol state and mail-id queue and loads the result register. The
// block takes one event word per clock, and the state update loop in the
// sequencer sets that rate. Back-pressure on the result channel stalls the
// input register. Configuration writes are always accepted and should be
// made while no event is in flight.
module smtp_client_reply_sequencer import scrs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  scrs_in_if.sink    in_ch,
  scrs_out_if.source out_ch,
  scrs_cfg_if.sink   cfg_ch
);

  logic       in_vld_r;
  logic [2:0] kind_r;
  logic [9:0] code_r;
  logic       final_r;

  logic       out_vld_r;
  result_t    res_r;
  result_t    res_nxt;

  logic [1:0] enc_mode_r;
  logic       auth_r;
  logic [3:0] rcpt_cnt_r;

  logic            fire;
  q_ctl_t          q_ctl;
  q_stat_t         q_stat;
  logic [ID_W-1:0] push_id;

  assign fire         = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !in_vld_r || fire;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      kind_r  <= in_ch.kind;
      code_r  <= in_ch.reply_code;
      final_r <= in_ch.final_line;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_mode_r <= MODE_NONE;
      auth_r     <= AUTH_LOGIN;
      rcpt_cnt_r <= 4'd1;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_IDX_ENC_MODE: enc_mode_r <= cfg_ch.data[1:0];
        CFG_IDX_AUTH:     auth_r     <= cfg_ch.data[0];
        CFG_IDX_RCPT_CNT: rcpt_cnt_r <= cfg_ch.data[3:0];
        default: ;
      endcase
    end
  end

  scrs_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (q_ctl),
    .push_id (push_id),
    .stat    (q_stat)
  );

  scrs_fsm u_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .kind        (kind_r),
    .reply_code  (code_r),
    .final_line  (final_r),
    .enc_mode    (enc_mode_r),
    .auth_method (auth_r),
    .rcpt_count  (rcpt_cnt_r),
    .q_stat      (q_stat),
    .q_ctl       (q_ctl),
    .push_id     (push_id),
    .result      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.command          = res_r.command;
  assign out_ch.recipient_slot   = res_r.recipient_slot;
  assign out_ch.link_action      = res_r.link_action;
  assign out_ch.report           = res_r.report;
  assign out_ch.report_mail_id   = res_r.report_mail_id;
  assign out_ch.assigned_mail_id = res_r.assigned_mail_id;
  assign out_ch.request_dropped  = res_r.request_dropped;
  assign out_ch.protocol_state   = res_r.protocol_state;

endmodule

// ===== verif/smtp_client_reply_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// smtp_client_reply_sequencer_tb
// Drives the SMTP client reply sequencer with directed dialogue fragments and
// long random dialogues under several register settings. A scoreboard keeps
// its own copy of the protocol state and mail-id queue and checks every
// result word field by field, while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module smtp_client_reply_sequencer_tb;
  import scrs_pkg::*;

  localparam int          ITEMS_PER_PHASE = 130;
  localparam int          NUM_PHASES      = 7;
  localparam int          CYCLE_LIMIT     = 300000;
  localparam int          LONG_HOLD       = 120;
  localparam int          DRAIN_CYCLES    = 8;
  localparam int          FLOOD_LEN       = QUEUE_DEPTH + 3;
  localparam logic [2:0]  KIND_UNKNOWN    = 3'd7;
  localparam logic [1:0]  MODE_UNUSED     = 2'd3;
  localparam logic        AUTH_PLAIN      = 1'b1;
  localparam logic [9:0]  RC_CLOSING      = 10'd221;

  class reply_scoreboard;
    logic [1:0]      enc_mode;
    logic            auth_sel;
    logic [3:0]      rcpt_cfg;
    seq_state_t      st;
    bit              link_enc;
    bit              testing;
    logic [3:0]      cursor;
    logic [ID_W-1:0] active_id;
    logic [ID_W-1:0] next_id;
    logic [ID_W-1:0] id_fifo [QUEUE_DEPTH];
    int unsigned     head, tail, fill;
    result_t         awaited [$];
    result_t         r;
    int              mismatches;
    int              checked;

    function new();
      enc_mode   = MODE_NONE;
      auth_sel   = AUTH_LOGIN;
      rcpt_cfg   = 4'd1;
      st         = ST_IDLE;
      link_enc   = 1'b0;
      testing    = 1'b0;
      cursor     = '0;
      active_id  = '0;
      next_id    = '0;
      head       = 0;
      tail       = 0;
      fill       = 0;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_IDX_ENC_MODE: enc_mode = val[1:0];
        CFG_IDX_AUTH:     auth_sel = val[0];
        CFG_IDX_RCPT_CNT: rcpt_cfg = val[3:0];
        default: ;
      endcase
    endfunction

    // The unused fourth encryption mode behaves like plain.
    function logic [1:0] mode_eff();
      return (enc_mode > MODE_STARTTLS) ? MODE_NONE : enc_mode;
    endfunction

    function int count_eff();
      int c;
      c = int'(rcpt_cfg);
      if (c == 0) c = 1;
      if (c > MAX_RECIPIENTS) c = MAX_RECIPIENTS;
      return c;
    endfunction

    function void link_connect();
      link_enc = 1'b0;
      r.link_action = (mode_eff() == MODE_SSL) ? LINK_CONNECT_SSL : LINK_CONNECT;
    endfunction

    function void link_close();
      link_enc = 1'b0;
      r.link_action = LINK_CLOSE;
    endfunction

    function void abort_dialogue();
      if (testing) begin
        r.report         = REP_LOGIN_FAIL;
        r.report_mail_id = '0;
      end else begin
        r.report         = REP_MAIL_FAIL;
        r.report_mail_id = active_id;
      end
      link_close();
      testing = 1'b0;
      st      = ST_IDLE;
    endfunction

    function void start_queued();
      if (st != ST_IDLE || fill == 0) return;
      active_id = id_fifo[Q_AW'(head)];
      head      = (head + 1) % QUEUE_DEPTH;
      fill--;
      st = ST_INIT;
      link_close();
      link_connect();
    endfunction

    function void login_done();
      st = testing ? ST_TESTDONE : ST_MAIL;
    endfunction

    function void on_reply(logic [9:0] code, logic fin);
      bit cont_ok;
      cont_ok = (code == RC_OK) && !fin;
      case (st)
        ST_IDLE: start_queued();
        ST_INIT: begin
          if (code == RC_READY) begin
            r.command = CMD_EHLO;
            case (mode_eff())
              MODE_NONE: st = ST_AUTH;
              MODE_SSL:  st = ST_HANDSHAKE;
              default:   st = ST_STARTTLS;
            endcase
          end
        end
        ST_HANDSHAKE: begin
          if (code == RC_READY) begin
            if (!link_enc && mode_eff() != MODE_NONE) r.link_action = LINK_START_TLS;
          end else if (code != RC_OK) begin
            abort_dialogue();
          end
        end
        ST_STARTTLS: begin
          if (!cont_ok) begin
            if (code == RC_OK) begin
              r.command = CMD_STARTTLS;
              st = ST_HANDSHAKE;
            end else abort_dialogue();
          end
        end
        ST_AUTH: begin
          if (!cont_ok) begin
            if (code == RC_OK || code == RC_READY) begin
              if (auth_sel == AUTH_LOGIN) begin
                r.command = CMD_AUTH_LOGIN;
                st = ST_USER;
              end else begin
                r.command = CMD_AUTH_PLAIN;
                login_done();
              end
            end else abort_dialogue();
          end
        end
        ST_USER: begin
          if (code == RC_CHALLENGE) begin
            r.command = CMD_USER;
            st = ST_PASS;
          end else abort_dialogue();
        end
        ST_PASS: begin
          if (code == RC_CHALLENGE) begin
            r.command = CMD_PASS;
            login_done();
          end else abort_dialogue();
        end
        ST_TESTDONE: begin
          if (code != RC_OK) begin
            r.report = (code == RC_AUTH_OK) ? REP_LOGIN_OK : REP_LOGIN_FAIL;
            r.report_mail_id = '0;
            link_close();
            testing = 1'b0;
          end
        end
        ST_MAIL: begin
          if (code == RC_AUTH_OK) begin
            r.command = CMD_MAIL_FROM;
            cursor = '0;
            st = ST_RCPT;
          end else if (code != RC_OK) abort_dialogue();
        end
        ST_RCPT: begin
          if (!cont_ok) begin
            if (code == RC_OK) begin
              r.command = CMD_RCPT;
              r.recipient_slot = cursor[2:0];
              cursor = cursor + 4'd1;
              if (int'(cursor) >= count_eff()) st = ST_DATA;
            end else abort_dialogue();
          end
        end
        ST_DATA: begin
          if (!cont_ok) begin
            if (code == RC_OK) begin
              r.command = CMD_DATA;
              st = ST_BODY;
            end else abort_dialogue();
          end
        end
        ST_BODY: begin
          if (code == RC_START_DATA) begin
            r.command = CMD_BODY;
            st = ST_QUIT;
          end else abort_dialogue();
        end
        ST_QUIT: begin
          if (!cont_ok) begin
            if (code == RC_OK) begin
              r.report = REP_MAIL_SENT;
              r.report_mail_id = active_id;
              r.command = CMD_QUIT;
              st = ST_CLOSE;
            end else abort_dialogue();
          end
        end
        ST_CLOSE: link_close();
        default: ;
      endcase
    endfunction

    function void note_event(logic [2:0] kind, logic [9:0] code, logic fin);
      r = '0;
      case (kind) inside
        KIND_REPLY: on_reply(code, fin);
        KIND_UNPARSABLE, KIND_SOCK_ERR: begin
          if (st != ST_IDLE) abort_dialogue();
        end
        KIND_ENCRYPTED: begin
          link_enc  = 1'b1;
          r.command = CMD_EHLO;
          st        = ST_AUTH;
        end
        KIND_CLOSED: begin
          link_enc = 1'b0;
          st       = ST_IDLE;
          start_queued();
        end
        KIND_MAIL_REQ: begin
          if (fill >= QUEUE_DEPTH) begin
            r.request_dropped = 1'b1;
          end else begin
            id_fifo[Q_AW'(tail)] = next_id;
            tail = (tail + 1) % QUEUE_DEPTH;
            fill++;
            r.assigned_mail_id = next_id;
            next_id = next_id + 1'b1;
          end
          start_queued();
        end
        KIND_TEST_LOGIN: begin
          testing = 1'b1;
          st      = ST_INIT;
          link_close();
          link_connect();
        end
        default: ;
      endcase
      r.protocol_state = st;
      awaited.push_back(r);
    endfunction

    task report_mismatch(string what, int unsigned exp_v, int unsigned got_v);
      mismatches++;
      if (mismatches <= 40)
        $display("mismatch in word %0d, %s: expected %0d, got %0d",
                 checked, what, exp_v, got_v);
    endtask

    task check_result(result_t got);
      result_t exp;
      checked++;
      if (awaited.size() == 0) begin
        report_mismatch("word with nothing awaited, state", 0, 32'(got.protocol_state));
        return;
      end
      exp = awaited.pop_front();
      if (got.command !== exp.command)
        report_mismatch("command", 32'(exp.command), 32'(got.command));
      if (got.recipient_slot !== exp.recipient_slot)
        report_mismatch("recipient_slot", 32'(exp.recipient_slot), 32'(got.recipient_slot));
      if (got.link_action !== exp.link_action)
        report_mismatch("link_action", 32'(exp.link_action), 32'(got.link_action));
      if (got.report !== exp.report)
        report_mismatch("report", 32'(exp.report), 32'(got.report));
      if (got.report_mail_id !== exp.report_mail_id)
        report_mismatch("report_mail_id", 32'(exp.report_mail_id), 32'(got.report_mail_id));
      if (got.assigned_mail_id !== exp.assigned_mail_id)
        report_mismatch("assigned_mail_id", 32'(exp.assigned_mail_id),
                        32'(got.assigned_mail_id));
      if (got.request_dropped !== exp.request_dropped)
        report_mismatch("request_dropped", 32'(exp.request_dropped),
                        32'(got.request_dropped));
      if (got.protocol_state !== exp.protocol_state)
        report_mismatch("protocol_state", 32'(exp.protocol_state), 32'(got.protocol_state));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic hold_request;
  int   cycle_count;

  reply_scoreboard sb;

  scrs_in_if  in_if ();
  scrs_out_if out_if ();
  scrs_cfg_if cfg_if ();

  smtp_client_reply_sequencer dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  logic [1:0] phase_mode [NUM_PHASES] =
    '{MODE_NONE, MODE_SSL, MODE_STARTTLS, MODE_UNUSED, MODE_STARTTLS, MODE_SSL, MODE_NONE};
  logic       phase_auth [NUM_PHASES] =
    '{AUTH_LOGIN, AUTH_PLAIN, AUTH_LOGIN, AUTH_PLAIN, AUTH_PLAIN, AUTH_LOGIN, AUTH_PLAIN};
  logic [3:0] phase_count [NUM_PHASES] =
    '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd5, 4'd2};

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("smtp_client_reply_sequencer_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t got;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.command          = out_if.command;
      got.recipient_slot   = out_if.recipient_slot;
      got.link_action      = out_if.link_action;
      got.report           = out_if.report;
      got.report_mail_id   = out_if.report_mail_id;
      got.assigned_mail_id = out_if.assigned_mail_id;
      got.request_dropped  = out_if.request_dropped;
      got.protocol_state   = out_if.protocol_state;
      sb.check_result(got);
    end
  end

  // Receiver: runs through stall patterns of random length, and once on request
  // holds off long enough for the block to fill and stall its input.
  initial begin : receiver
    int  hold_left;
    int  mode_left;
    int  mode;
    bit  hold_served;
    hold_left   = 0;
    mode_left   = 0;
    mode        = 0;
    hold_served = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else if (hold_request && !hold_served) begin
        hold_served = 1'b1;
        hold_left   = LONG_HOLD;
        out_if.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          2:       out_if.ready <= ($urandom_range(0, 3) != 0);
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
        if ($urandom_range(0, 999) == 0) hold_left = 50;
      end
    end
  end

  task automatic send_event(input logic [2:0] k, input logic [9:0] c, input logic f);
    in_if.valid      <= 1'b1;
    in_if.kind       <= k;
    in_if.reply_code <= c;
    in_if.final_line <= f;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_event(k, c, f);
  endtask

  task automatic send_reply(input logic [9:0] c, input logic f);
    send_event(KIND_REPLY, c, f);
  endtask

  task automatic sender_gap(input int n);
    if (n > 0) begin
      in_if.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_if.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_config(idx, val);
  endtask

  function automatic logic [9:0] known_code();
    case ($urandom_range(0, 5))
      0:       return RC_READY;
      1:       return RC_OK;
      2:       return RC_CHALLENGE;
      3:       return RC_AUTH_OK;
      4:       return RC_START_DATA;
      default: return RC_CLOSING;
    endcase
  endfunction

  // Picks the event that a well-behaved server and link would produce next,
  // with the odd harmless continuation line mixed in.
  task automatic choose_event(output logic [2:0] k, output logic [9:0] c, output logic f);
    int roll;
    roll = $urandom_range(0, 99);
    k = KIND_REPLY;
    c = RC_OK;
    f = 1'b1;
    case (sb.st) inside
      ST_IDLE: begin
        if (sb.fill != 0) k = KIND_CLOSED;
        else k = (roll < 85) ? KIND_MAIL_REQ : KIND_TEST_LOGIN;
        c = 10'($urandom_range(0, 1023));
        f = 1'($urandom_range(0, 1));
      end
      ST_INIT: c = RC_READY;
      ST_HANDSHAKE: begin
        if (roll < 40) c = RC_READY;
        else if (roll < 55) f = 1'($urandom_range(0, 1));
        else k = KIND_ENCRYPTED;
      end
      ST_AUTH: begin
        if (roll < 20) f = 1'b0;
        else if (roll < 40) c = RC_READY;
      end
      ST_USER, ST_PASS: begin
        c = RC_CHALLENGE;
        f = 1'($urandom_range(0, 1));
      end
      ST_TESTDONE: begin
        if (roll < 70) c = RC_AUTH_OK;
        else if (roll >= 85) c = 10'($urandom_range(0, 1023));
      end
      ST_MAIL: if (roll >= 15) c = RC_AUTH_OK;
      ST_BODY: c = RC_START_DATA;
      ST_CLOSE: begin
        if (roll < 30) begin
          c = 10'($urandom_range(0, 1023));
          f = 1'($urandom_range(0, 1));
        end else k = KIND_CLOSED;
      end
      default: if (roll < 20) f = 1'b0;
    endcase
  endtask

  task automatic run_directed();
    send_reply(10'd0, 1'b0);
    send_reply(10'd1023, 1'b1);
    send_event(KIND_UNKNOWN, 10'd1023, 1'b1);
    send_event(KIND_UNPARSABLE, 10'd0, 1'b0);
    send_event(KIND_SOCK_ERR, 10'd0, 1'b0);
    send_event(KIND_ENCRYPTED, 10'd0, 1'b0);
    send_event(KIND_CLOSED, 10'd0, 1'b0);
    sender_gap(3);
    // Full test-login pass with continuation lines that must be ignored.
    send_event(KIND_TEST_LOGIN, 10'd0, 1'b0);
    send_reply(RC_READY, 1'b1);
    send_reply(RC_OK, 1'b0);
    send_reply(RC_OK, 1'b1);
    send_reply(RC_CHALLENGE, 1'b1);
    send_reply(RC_CHALLENGE, 1'b1);
    send_reply(RC_OK, 1'b1);
    send_reply(RC_AUTH_OK, 1'b1);
    send_event(KIND_CLOSED, 10'd0, 1'b0);
    sender_gap(2);
    // A mail that fails on an unexpected code, then one lost to a socket error.
    send_event(KIND_MAIL_REQ, 10'd0, 1'b0);
    send_reply(RC_READY, 1'b1);
    send_reply(RC_OK, 1'b1);
    send_reply(10'd999, 1'b1);
    send_event(KIND_MAIL_REQ, 10'd0, 1'b0);
    send_event(KIND_SOCK_ERR, 10'd0, 1'b0);
    send_event(KIND_CLOSED, 10'd0, 1'b0);
    // Test login while a mail is starting restarts the dialogue.
    send_event(KIND_MAIL_REQ, 10'd0, 1'b0);
    send_event(KIND_TEST_LOGIN, 10'd0, 1'b0);
    send_event(KIND_UNPARSABLE, 10'd0, 1'b0);
    send_event(KIND_CLOSED, 10'd0, 1'b0);
  endtask

  task automatic run_random(input int phase);
    int         sent;
    int         burst_left;
    int         roll;
    logic [2:0] k;
    logic [9:0] c;
    logic       f;
    sent       = 0;
    burst_left = 0;
    while (sent < ITEMS_PER_PHASE) begin
      if (burst_left == 0) begin
        sender_gap(($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6));
        burst_left = $urandom_range(1, 24);
      end
      if (phase == 2 && sent >= 20) hold_request <= 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 1) begin
        // A run of requests long enough to overflow the mail-id queue.
        repeat (FLOOD_LEN) send_event(KIND_MAIL_REQ, 10'($urandom_range(0, 1023)), 1'b0);
        sent += FLOOD_LEN;
      end else begin
        if (roll < 80) begin
          choose_event(k, c, f);
        end else if (roll < 88) begin
          k = KIND_MAIL_REQ;
          c = 10'($urandom_range(0, 1023));
          f = 1'($urandom_range(0, 1));
        end else if (roll < 91) begin
          k = KIND_TEST_LOGIN;
          c = 10'($urandom_range(0, 1023));
          f = 1'($urandom_range(0, 1));
        end else begin
          k = 3'($urandom_range(0, 7));
          c = $urandom_range(0, 1) ? known_code() : 10'($urandom_range(0, 1023));
          f = 1'($urandom_range(0, 1));
        end
        send_event(k, c, f);
        sent++;
      end
      if (burst_left > 0) burst_left--;
    end
  endtask

  initial begin
    sb = new();
    cycle_count      = 0;
    hold_request     = 1'b0;
    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.kind       = KIND_REPLY;
    in_if.reply_code = '0;
    in_if.final_line = 1'b0;
    cfg_if.valid     = 1'b0;
    cfg_if.index     = CFG_IDX_ENC_MODE;
    cfg_if.data      = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_IDX_ENC_MODE, CFG_DATA_W'(phase_mode[p]));
      write_reg(CFG_IDX_AUTH, CFG_DATA_W'(phase_auth[p]));
      write_reg(CFG_IDX_RCPT_CNT, phase_count[p]);
      cfg_if.valid <= 1'b0;
      run_random(p);
      drain_results();
    end

    if (sb.mismatches == 0 && sb.awaited.size() == 0) begin
      $display("smtp_client_reply_sequencer_tb: PASS");
    end else begin
      $display("smtp_client_reply_sequencer_tb: FAIL");
    end
    $finish;
  end

endmodule
